// ----- src/pfb_pkg.sv -----
package pfb_pkg;

  // Default screen size in pixels.
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  // Blit byte index width; the index wraps at its top value.
  localparam int IDX_W = 11;

  // Reset value of the image height register.
  localparam logic [6:0] HEIGHT_RESET = 7'd8;

  // Operation codes.
  localparam logic [1:0] FUNC_BLIT  = 2'd0;
  localparam logic [1:0] FUNC_PIXEL = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Merge rules.
  localparam logic [1:0] COLOR_WHITE   = 2'd0;
  localparam logic [1:0] COLOR_BLACK   = 2'd1;
  localparam logic [1:0] COLOR_INVERSE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_COLOR  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_WR0   = 6'b001000,
    S_WR1   = 6'b010000,
    S_RDOUT = 6'b100000
  } state_t;

  // Merge a mask of pixels into a stored byte under the given rule.
  function automatic logic [7:0] merge_byte(input logic [7:0] old_byte,
                                            input logic [7:0] bits,
                                            input logic [1:0] mode);
    logic [7:0] res;
    unique case (mode)
      COLOR_WHITE:   res = old_byte | bits;
      COLOR_BLACK:   res = old_byte & ~bits;
      COLOR_INVERSE: res = old_byte ^ bits;
      default:       res = old_byte;
    endcase
    return res;
  endfunction

endpackage

// ----- src/pfb_ram.sv -----
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/page_framebuffer_blitter_unit.sv -----
// Page-organized 1-bit-per-pixel frame store with a column-byte blitter.
//
// Commands enter on start with func and its operand fields; a command is taken
// at a rising edge where start is high and busy is low. A blit byte (with first
// marking the opening byte of an image) keeps busy high until its last step is
// done: the transfer cycle reads the upper target byte, the next writes it back
// merged while reading the lower byte, and a last step writes that. A byte that
// only touches one page, and a set pixel, skip the last step. On a read, read_data
// comes with done in the cycle right after the transfer, and the receiver cannot
// hold it off, so it is never delayed. A clear writes zero to every store byte,
// one store byte per cycle, set by the single write port of the frame store.
// Configuration writes (cfg_en, cfg_index, cfg_data) take effect at once.
// Writing image_height starts a restoring division of the running byte index by
// the page count once idle, so a blit in progress keeps its place; busy stays
// high meanwhile. After reset the store is swept to zero, which holds busy high
// until all SCREEN_WIDTH * NUM_PAGES bytes (1024 by default) are written.
module page_framebuffer_blitter_unit #(
  parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic              first,
  input  logic [7:0]        data_byte,
  input  logic signed [8:0] x_pos,
  input  logic signed [8:0] y_pos,
  input  logic [9:0]        read_addr,
  output logic              done,
  output logic [7:0]        read_data,
  input  logic              cfg_en,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  import pfb_pkg::*;

  localparam int NUM_PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH     = SCREEN_WIDTH * NUM_PAGES;
  localparam int AW        = $clog2(DEPTH);

  state_t state;

  // Configuration registers.
  logic [1:0] color_mode;
  logic [6:0] image_height;

  // Blit position: running byte index, plus its quotient (column offset) and
  // remainder (source page) by the page count, kept up to date incrementally.
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] col_off;
  logic [3:0]       pg;
  logic [8:0]       origin_x;
  logic [8:0]       origin_y;

  // Division run after the page count changes.
  logic             div_pending;
  logic [IDX_W-1:0] div_q;
  logic [4:0]       div_r;
  logic [3:0]       div_cnt;

  logic [AW-1:0] clr_cnt;

  // Targets captured at transfer time.
  logic [AW-1:0] addr0_q;
  logic [AW-1:0] addr1_q;
  logic [7:0]    mask0_q;
  logic [7:0]    mask1_q;
  logic          en0_q;
  logic          en1_q;
  logic          rd_ok_q;

  // Frame store port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic accept;
  logic height_wr;

  // Page count from the image height; a zero height counts as one page.
  logic [6:0] h_m1;
  logic [4:0] pages;

  // Blit target computation.
  logic [8:0]       ox;
  logic [8:0]       oy;
  logic [IDX_W-1:0] idx_use;
  logic [IDX_W-1:0] col_off_use;
  logic [3:0]       pg_use;
  logic [12:0]      blit_col;
  logic [6:0]       page0;
  logic [6:0]       page1;
  logic [15:0]      shifted;
  logic             col_ok;
  logic             page0_ok;
  logic             page1_ok;
  logic [11:0]      blit_addr0;
  logic [11:0]      blit_addr1;
  logic [4:0]       pg_inc;

  // Set pixel target.
  logic        px_ok;
  logic [11:0] px_addr;

  // Read target.
  logic [11:0] rd_full;
  logic        rd_ok;

  // Division step.
  logic [5:0] div_t;
  logic       div_ge;
  logic [4:0] div_r_new;

  assign height_wr = cfg_en && (cfg_index == CFG_HEIGHT);
  assign busy      = (state != S_IDLE) || div_pending || height_wr;
  assign accept    = start && !busy;

  assign h_m1  = (image_height == 7'd0) ? 7'd0 : image_height - 7'd1;
  assign pages = {1'b0, h_m1[6:3]} + 5'd1;

  // A first byte starts from the fields on the ports; later bytes continue
  // from the latched origin and the running position.
  assign ox          = first ? x_pos : origin_x;
  assign oy          = first ? y_pos : origin_y;
  assign idx_use     = first ? '0 : byte_index;
  assign col_off_use = first ? '0 : col_off;
  assign pg_use      = first ? '0 : pg;

  assign blit_col = {{4{ox[8]}}, ox} + {2'b00, col_off_use};
  // The page of the origin is floor(oy / 8), an arithmetic shift.
  assign page0    = {oy[8], oy[8:3]} + {3'b000, pg_use};
  assign page1    = page0 + 7'd1;
  // The low byte lands in the upper page, the high byte spills into the next.
  assign shifted  = {8'h00, data_byte} << oy[2:0];

  assign col_ok   = !blit_col[12] && (blit_col[11:0] < 12'(SCREEN_WIDTH));
  assign page0_ok = !page0[6] && (page0[5:0] < 6'(NUM_PAGES));
  assign page1_ok = !page1[6] && (page1[5:0] < 6'(NUM_PAGES));

  assign blit_addr0 = 12'(page0[2:0]) * 12'(SCREEN_WIDTH) + 12'(blit_col[7:0]);
  assign blit_addr1 = 12'(page1[2:0]) * 12'(SCREEN_WIDTH) + 12'(blit_col[7:0]);

  assign pg_inc = {1'b0, pg_use} + 5'd1;

  assign px_ok = !x_pos[8] && ({1'b0, x_pos[7:0]} < 9'(SCREEN_WIDTH)) &&
                 !y_pos[8] && ({1'b0, y_pos[7:0]} < 9'(SCREEN_HEIGHT));
  assign px_addr = 12'(y_pos[5:3]) * 12'(SCREEN_WIDTH) + 12'(x_pos[7:0]);

  assign rd_full = 12'(read_addr);
  assign rd_ok   = rd_full < 12'(DEPTH);

  assign div_t     = {div_r, div_q[IDX_W-1]};
  assign div_ge    = div_t >= {1'b0, pages};
  assign div_r_new = div_ge ? 5'(div_t - {1'b0, pages}) : div_t[4:0];

  // Frame store access. Reads are issued at transfer time and in the first
  // write-back cycle; each read result is consumed in the following cycle, so
  // the two bytes of a blit never overlap in flight.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr0_q;
    ram_wdata = 8'h00;
    ram_raddr = addr0_q;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        if (func == FUNC_READ) begin
          ram_raddr = rd_full[AW-1:0];
        end else if (func == FUNC_PIXEL) begin
          ram_raddr = px_addr[AW-1:0];
        end else begin
          ram_raddr = blit_addr0[AW-1:0];
        end
      end
      S_WR0: begin
        ram_we    = en0_q;
        ram_wdata = merge_byte(ram_rdata, mask0_q, color_mode);
        ram_raddr = addr1_q;
      end
      S_WR1: begin
        ram_we    = en1_q;
        ram_waddr = addr1_q;
        ram_wdata = merge_byte(ram_rdata, mask1_q, color_mode);
      end
      default: begin
      end
    endcase
  end

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign done      = (state == S_RDOUT);
  assign read_data = rd_ok_q ? ram_rdata : 8'h00;

  // Configuration registers and the pending-division flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= COLOR_WHITE;
      image_height <= HEIGHT_RESET;
      div_pending  <= 1'b0;
    end else begin
      if (cfg_en) begin
        if (cfg_index == CFG_COLOR) begin
          color_mode <= cfg_data[1:0];
        end else begin
          image_height <= cfg_data;
        end
      end
      if (height_wr) begin
        div_pending <= 1'b1;
      end else if (state == S_IDLE) begin
        div_pending <= 1'b0;
      end
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      byte_index <= '0;
      col_off    <= '0;
      pg         <= '0;
      origin_x   <= '0;
      origin_y   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (div_pending) begin
            state <= S_DIV;
          end else if (accept) begin
            unique case (func)
              FUNC_BLIT: begin
                state <= S_WR0;
                if (first) begin
                  origin_x <= x_pos;
                  origin_y <= y_pos;
                end
                byte_index <= idx_use + 1'b1;
                // When the index wraps, the position restarts at zero too.
                if (idx_use == '1) begin
                  col_off <= '0;
                  pg      <= '0;
                end else if (pg_inc == pages) begin
                  col_off <= col_off_use + 1'b1;
                  pg      <= '0;
                end else begin
                  col_off <= col_off_use;
                  pg      <= pg_inc[3:0];
                end
              end
              FUNC_PIXEL: state <= S_WR0;
              FUNC_READ:  state <= S_RDOUT;
              FUNC_CLEAR: begin
                state   <= S_CLEAR;
                clr_cnt <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_cnt == 4'(IDX_W - 1)) begin
            col_off <= {div_q[IDX_W-2:0], div_ge};
            pg      <= div_r_new[3:0];
            state   <= S_IDLE;
          end
        end
        S_WR0: begin
          state <= en1_q ? S_WR1 : S_IDLE;
        end
        S_WR1: begin
          state <= S_IDLE;
        end
        S_RDOUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: division iterations and the captured targets.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      div_q   <= byte_index;
      div_r   <= '0;
      div_cnt <= '0;
    end else if (state == S_DIV) begin
      div_q   <= {div_q[IDX_W-2:0], div_ge};
      div_r   <= div_r_new;
      div_cnt <= div_cnt + 4'd1;
    end

    if (accept) begin
      rd_ok_q <= rd_ok;
      if (func == FUNC_PIXEL) begin
        addr0_q <= px_addr[AW-1:0];
        addr1_q <= px_addr[AW-1:0];
        mask0_q <= 8'h01 << y_pos[2:0];
        mask1_q <= 8'h00;
        en0_q   <= px_ok;
        en1_q   <= 1'b0;
      end else begin
        addr0_q <= blit_addr0[AW-1:0];
        addr1_q <= blit_addr1[AW-1:0];
        mask0_q <= shifted[7:0];
        mask1_q <= shifted[15:8];
        en0_q   <= col_ok && page0_ok;
        en1_q   <= col_ok && page1_ok && (oy[2:0] != 3'd0);
      end
    end
  end

endmodule
